// ===== hw/rtl/nsfc_pkg.sv =====
`timescale 1ns / 1ps

package nsfc_pkg;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_NUL    = 8'h00;

	localparam logic [1:0] KIND_OTHER = 2'd0;
	localparam logic [1:0] KIND_RMC   = 2'd1;
	localparam logic [1:0] KIND_GGA   = 2'd2;

	localparam int PREFIX_LEN = 6;
	localparam int PREFIX_CNT = 4;

	// last '*' with two bytes after it
	typedef struct packed {
		logic       valid;
		logic [7:0] xr;
		logic [7:0] hi;
		logic [7:0] lo;
	} cand_t;

	// what the framer hands to the checker when a sentence closes
	typedef struct packed {
		logic                  fire;
		cand_t                 cand;
		logic [PREFIX_CNT-1:0] flags;
		logic [7:0]            length;
	} close_t;

	// $GPRMC, $GNRMC, $GPGGA, $GNGGA
	function automatic logic [7:0] prefix_char(input logic [1:0] p, input logic [2:0] k);
		logic [7:0] c;
		unique case (k)
			3'd0: c = CH_DOLLAR;
			3'd1: c = 8'h47;
			3'd2: c = p[0] ? 8'h4E : 8'h50;
			3'd3: c = p[1] ? 8'h47 : 8'h52;
			3'd4: c = p[1] ? 8'h47 : 8'h4D;
			3'd5: c = p[1] ? 8'h41 : 8'h43;
			default: c = 8'hFF;
		endcase
		return c;
	endfunction

	// bit 4 set means not a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = {1'b0, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = {1'b0, 4'(c - 8'h57)};
		end else begin
			v = 5'h10;
		end
		return v;
	endfunction

endpackage

// ===== hw/rtl/nsfc_framer.sv =====
`timescale 1ns / 1ps

module nsfc_framer #(
	parameter int BUFFER_BYTES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       byte_in,
	output nsfc_pkg::close_t info
);
	import nsfc_pkg::*;

	localparam int FW = $clog2(BUFFER_BYTES);
	localparam int LW = (FW > 8) ? FW : 8;

	logic [FW-1:0]         fill_q, n_fill, k;
	logic [LW-1:0]         text_len_q, n_text;
	logic                  swd_q, n_swd;
	logic                  zs_q, n_zs;
	logic [7:0]            xor_q, n_xor;
	logic [7:0]            rb_q [3];
	logic [7:0]            n_rb [3];
	logic [7:0]            rx_q [3];
	logic [7:0]            n_rx [3];
	cand_t                 cand_q, n_cand;
	logic [PREFIX_CNT-1:0] flags_q, n_flags;
	logic                  is_dollar, is_nl, app, clr_nl;

	always_comb begin
		is_dollar = (byte_in == CH_DOLLAR);
		is_nl     = (byte_in == CH_LF) || (byte_in == CH_CR);
		app       = is_dollar || (!is_nl && fill_q < FW'(BUFFER_BYTES - 1));
		clr_nl    = is_nl && (fill_q != '0) && swd_q;

		n_fill  = fill_q;
		n_text  = text_len_q;
		n_swd   = swd_q;
		n_zs    = zs_q;
		n_xor   = xor_q;
		n_rb    = rb_q;
		n_rx    = rx_q;
		n_cand  = cand_q;
		n_flags = flags_q;
		k       = '0;

		// a '$', or a line end after a buffer that began with '$', closes the buffer
		if (is_dollar || (!app && clr_nl)) begin
			n_fill  = '0;
			n_text  = '0;
			n_swd   = 1'b0;
			n_zs    = 1'b0;
			n_xor   = '0;
			n_rb    = '{default: '0};
			n_rx    = '{default: '0};
			n_cand  = '0;
			n_flags = '1;
		end

		if (app) begin
			k = n_fill;
			if (k == '0) begin
				n_swd = is_dollar;
			end
			n_fill = k + FW'(1);
			if (!n_zs) begin
				if (byte_in == CH_NUL) begin
					n_zs    = 1'b1;
					n_flags = '0;
				end else begin
					n_text = LW'(k) + LW'(1);
					if (k < FW'(PREFIX_LEN)) begin
						for (int p = 0; p < PREFIX_CNT; p++) begin
							if (prefix_char(2'(p), k[2:0]) != byte_in) begin
								n_flags[p] = 1'b0;
							end
						end
					end
					if (k >= FW'(2) && n_rb[1] == CH_STAR) begin
						n_cand = '{valid: 1'b1, xr: n_rx[1], hi: n_rb[0], lo: byte_in};
					end
					n_rb[2] = n_rb[1];
					n_rb[1] = n_rb[0];
					n_rb[0] = byte_in;
					n_rx[2] = n_rx[1];
					n_rx[1] = n_rx[0];
					n_rx[0] = n_xor;
					if (k >= FW'(1)) begin
						n_xor = n_xor ^ byte_in;
					end
				end
			end
		end
	end

	always_comb begin
		info.fire   = (text_len_q > LW'(PREFIX_LEN)) && (is_dollar || clr_nl);
		info.cand   = cand_q;
		info.flags  = flags_q;
		info.length = text_len_q[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			text_len_q <= '0;
			swd_q      <= 1'b0;
			zs_q       <= 1'b0;
			xor_q      <= '0;
			rb_q       <= '{default: '0};
			rx_q       <= '{default: '0};
			cand_q     <= '0;
			flags_q    <= '1;
		end else if (step) begin
			fill_q     <= n_fill;
			text_len_q <= n_text;
			swd_q      <= n_swd;
			zs_q       <= n_zs;
			xor_q      <= n_xor;
			rb_q       <= n_rb;
			rx_q       <= n_rx;
			cand_q     <= n_cand;
			flags_q    <= n_flags;
		end
	end

endmodule

// ===== hw/rtl/nsfc_checker.sv =====
`timescale 1ns / 1ps

module nsfc_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             stall,
	input  nsfc_pkg::close_t info,
	output logic             valid,
	output logic             checksum_ok,
	output logic [1:0]       sentence_kind,
	output logic [7:0]       sentence_length,
	output logic [31:0]      total_closed,
	output logic [31:0]      total_valid,
	output logic [31:0]      total_rmc,
	output logic [31:0]      total_gga
);
	import nsfc_pkg::*;

	logic [4:0]  hi, lo;
	logic        ok;
	logic [1:0]  kind;
	logic        valid_q, ok_q;
	logic [1:0]  kind_q;
	logic [7:0]  len_q;
	logic [31:0] closed_q, good_q, rmc_q, gga_q;

	always_comb begin
		hi = hex_val(info.cand.hi);
		lo = hex_val(info.cand.lo);
		ok = info.cand.valid && !hi[4] && !lo[4] && ({hi[3:0], lo[3:0]} == info.cand.xr);
		priority if (!ok) begin
			kind = KIND_OTHER;
		end else if (|info.flags[1:0]) begin
			kind = KIND_RMC;
		end else if (|info.flags[3:2]) begin
			kind = KIND_GGA;
		end else begin
			kind = KIND_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			closed_q <= '0;
			good_q   <= '0;
			rmc_q    <= '0;
			gga_q    <= '0;
		end else if (load) begin
			valid_q  <= 1'b1;
			closed_q <= closed_q + 32'd1;
			if (ok) begin
				good_q <= good_q + 32'd1;
			end
			if (kind == KIND_RMC) begin
				rmc_q <= rmc_q + 32'd1;
			end
			if (kind == KIND_GGA) begin
				gga_q <= gga_q + 32'd1;
			end
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ok_q   <= ok;
			kind_q <= kind;
			len_q  <= info.length;
		end
	end

	// counters only move on load, so they already hold this sentence's values
	assign valid           = valid_q;
	assign checksum_ok     = ok_q;
	assign sentence_kind   = kind_q;
	assign sentence_length = len_q;
	assign total_closed    = closed_q;
	assign total_valid     = good_q;
	assign total_rmc       = rmc_q;
	assign total_gga       = gga_q;

endmodule

// ===== hw/rtl/nmea_sentence_framer_checker_unit.sv =====
`timescale 1ns / 1ps
// channel | signals                                   | direction
// in      | in_valid, in_stall, rx_byte               | bytes in
// out     | out_valid, out_stall, checksum_ok,        | one result per closed
//         | sentence_kind, sentence_length, total_*   | sentence over 6 bytes
// one byte per cycle while in_stall is low; a byte sits in the input register, the
// framer updates its state and a closing byte writes the result register.
// in_stall rises only when a closing byte meets a full, stalled result register;
// other bytes keep flowing under an output stall.
// reset clears the sentence buffer state and all four counters.

module nmea_sentence_framer_checker_unit #(
	parameter int BUFFER_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        checksum_ok,
	output logic [1:0]  sentence_kind,
	output logic [7:0]  sentence_length,
	output logic [31:0] total_closed,
	output logic [31:0] total_valid,
	output logic [31:0] total_rmc,
	output logic [31:0] total_gga
);
	import nsfc_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	close_t     info;
	logic       advance, load;

	assign load     = valid_s1 && info.fire && !(out_valid && out_stall);
	assign advance  = valid_s1 && !(info.fire && out_valid && out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	nsfc_framer #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.byte_in(byte_s1),
		.info   (info)
	);

	nsfc_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (load),
		.stall          (out_stall),
		.info           (info),
		.valid          (out_valid),
		.checksum_ok    (checksum_ok),
		.sentence_kind  (sentence_kind),
		.sentence_length(sentence_length),
		.total_closed   (total_closed),
		.total_valid    (total_valid),
		.total_rmc      (total_rmc),
		.total_gga      (total_gga)
	);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && info.fire))
		else $error("input stalled without a blocked result");

	a_closed_count: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (total_closed == $past(total_closed) + 32'd1))
		else $error("closed count did not advance on a result");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !load) |=> !out_valid)
		else $error("result stayed after its transfer");

	a_kind_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (checksum_ok || sentence_kind == KIND_OTHER))
		else $error("kind reported on a failed checksum");

endmodule

// ===== test/tb_nmea_sentence_framer_checker_unit.sv =====
`timescale 1ns / 1ps

module tb_nmea_sentence_framer_checker_unit;
	import nsfc_pkg::*;

	localparam int BUF_BYTES   = 256;
	localparam int HOLD_CYCLES = 150;
	localparam int IDLE_LIMIT  = 2000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic        ok;
		logic [1:0]  kind;
		logic [7:0]  len;
		logic [31:0] n_closed;
		logic [31:0] n_valid;
		logic [31:0] n_rmc;
		logic [31:0] n_gga;
	} sentence_t;

	typedef enum {CS_UPPER, CS_LOWER, CS_WRONG, CS_NOT_HEX, CS_NONE} sum_style_t;
	typedef enum {END_CRLF, END_LF, END_CR, END_OPEN} line_end_t;

	// frames the byte stream and predicts the result of each closed sentence
	class sentence_tracker;
		int unsigned fill;
		int unsigned text_len;
		bit          dollar_first;
		bit          zero_seen;
		logic [7:0]  xor_acc;
		logic [7:0]  last_bytes[3];
		logic [7:0]  last_xor[3];
		bit          star_valid;
		logic [7:0]  star_xor;
		logic [7:0]  star_hi;
		logic [7:0]  star_lo;
		logic [3:0]  kind_flags;
		logic [31:0] n_closed;
		logic [31:0] n_valid;
		logic [31:0] n_rmc;
		logic [31:0] n_gga;
		string       talker_prefix[4];
		sentence_t   expected_q[$];
		int          mismatches;

		function new();
			talker_prefix[0] = "$GPRMC";
			talker_prefix[1] = "$GNRMC";
			talker_prefix[2] = "$GPGGA";
			talker_prefix[3] = "$GNGGA";
			n_closed = 0;
			n_valid = 0;
			n_rmc = 0;
			n_gga = 0;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			fill = 0;
			text_len = 0;
			dollar_first = 0;
			zero_seen = 0;
			xor_acc = '0;
			for (int i = 0; i < 3; i++) begin
				last_bytes[i] = '0;
				last_xor[i] = '0;
			end
			star_valid = 0;
			star_xor = '0;
			star_hi = '0;
			star_lo = '0;
			kind_flags = '1;
		endfunction

		function int hex_nibble(logic [7:0] c);
			if (c >= "0" && c <= "9") return c - "0";
			if (c >= "A" && c <= "F") return c - "A" + 10;
			if (c >= "a" && c <= "f") return c - "a" + 10;
			return 16;
		endfunction

		function void store(logic [7:0] b);
			int unsigned k;
			k = fill;
			if (k == 0) dollar_first = (b == CH_DOLLAR);
			fill = k + 1;
			if (zero_seen) return;
			if (b == CH_NUL) begin
				zero_seen = 1;
				kind_flags = '0;
				return;
			end
			text_len = k + 1;
			if (k < 6) begin
				for (int p = 0; p < 4; p++) begin
					if (talker_prefix[p][k] != b) kind_flags[p] = 1'b0;
				end
			end
			last_bytes[2] = last_bytes[1];
			last_bytes[1] = last_bytes[0];
			last_bytes[0] = b;
			last_xor[2] = last_xor[1];
			last_xor[1] = last_xor[0];
			last_xor[0] = xor_acc;
			if (k >= 1) xor_acc ^= b;
			if (k >= 2 && last_bytes[2] == CH_STAR) begin
				star_valid = 1;
				star_xor = last_xor[2];
				star_hi = last_bytes[1];
				star_lo = last_bytes[0];
			end
		endfunction

		function void close_sentence();
			sentence_t want;
			int hi;
			int lo;
			if (text_len <= 6) return;
			n_closed++;
			want.ok = 1'b0;
			want.kind = KIND_OTHER;
			if (star_valid) begin
				hi = hex_nibble(star_hi);
				lo = hex_nibble(star_lo);
				if (hi < 16 && lo < 16 && hi * 16 + lo == star_xor) want.ok = 1'b1;
			end
			if (want.ok) begin
				n_valid++;
				if (kind_flags[1:0] != 0) begin
					want.kind = KIND_RMC;
					n_rmc++;
				end else if (kind_flags[3:2] != 0) begin
					want.kind = KIND_GGA;
					n_gga++;
				end
			end
			want.len = 8'(text_len);
			want.n_closed = n_closed;
			want.n_valid = n_valid;
			want.n_rmc = n_rmc;
			want.n_gga = n_gga;
			expected_q.push_back(want);
		endfunction

		function void note_byte(logic [7:0] b);
			if (b == CH_DOLLAR) begin
				if (fill > 0) close_sentence();
				restart();
				store(b);
			end else if (b == CH_LF || b == CH_CR) begin
				if (fill > 0 && dollar_first) begin
					close_sentence();
					restart();
				end
			end else if (fill < BUF_BYTES - 1) begin
				store(b);
			end
		endfunction

		function void check_sentence(sentence_t got);
			sentence_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected sentence result ok %0d kind %0d len %0d closed %0d",
						$time, got.ok, got.kind, got.len, got.n_closed);
				return;
			end
			want = expected_q.pop_front();
			if (got.ok !== want.ok || got.kind !== want.kind || got.len !== want.len
					|| got.n_closed !== want.n_closed || got.n_valid !== want.n_valid
					|| got.n_rmc !== want.n_rmc || got.n_gga !== want.n_gga) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: sentence mismatch", $time);
					$display("  expected ok %0d kind %0d len %0d closed %0d valid %0d rmc %0d gga %0d",
						want.ok, want.kind, want.len, want.n_closed, want.n_valid,
						want.n_rmc, want.n_gga);
					$display("  actual   ok %0d kind %0d len %0d closed %0d valid %0d rmc %0d gga %0d",
						got.ok, got.kind, got.len, got.n_closed, got.n_valid,
						got.n_rmc, got.n_gga);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        checksum_ok;
	logic [1:0]  sentence_kind;
	logic [7:0]  sentence_length;
	logic [31:0] total_closed;
	logic [31:0] total_valid;
	logic [31:0] total_rmc;
	logic [31:0] total_gga;

	sentence_tracker tracker = new();

	logic [7:0] tx_bytes[$];
	logic [7:0] frame_xor;
	int         frame_pos;
	int         bytes_sent = 0;
	int         burst_left = 0;
	bit         sender_gaps = 0;
	int         long_count = 0;
	int         stall_style = 0;
	int         hold_requests = 0;
	int         holds_served = 0;
	int         hold_left = 0;
	int         rx_cycle = 0;
	int         quiet_cycles = 0;

	nmea_sentence_framer_checker_unit #(
		.BUFFER_BYTES(BUF_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.checksum_ok(checksum_ok),
		.sentence_kind(sentence_kind),
		.sentence_length(sentence_length),
		.total_closed(total_closed),
		.total_valid(total_valid),
		.total_rmc(total_rmc),
		.total_gga(total_gga)
	);

	always #1 clk = ~clk;

	// result side: stall styles plus long hold-offs on request
	always @(negedge clk) begin
		rx_cycle++;
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_requests != holds_served) begin
			holds_served++;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			case (stall_style)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ((rx_cycle % 11) < 4);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_sentence('{checksum_ok, sentence_kind, sentence_length,
				total_closed, total_valid, total_rmc, total_gga});
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [7:0] hex_char(logic [3:0] v, bit lower);
		if (v < 10) return 8'("0") + v;
		return 8'((lower ? 8'("a") : 8'("A")) + v - 10);
	endfunction

	function automatic void begin_frame();
		frame_xor = '0;
		frame_pos = 0;
	endfunction

	function automatic void put(logic [7:0] b);
		tx_bytes.push_back(b);
		if (frame_pos > 0) frame_xor ^= b;
		frame_pos++;
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++) put(s[i]);
	endfunction

	function automatic void finish_frame(sum_style_t cs, line_end_t term);
		logic [7:0] sum;
		string      not_hex;
		int         pick;
		sum = frame_xor;
		not_hex = "GgZz:/@`~ ";
		case (cs)
			CS_UPPER, CS_LOWER: begin
				put(CH_STAR);
				put(hex_char(sum[7:4], cs == CS_LOWER));
				put(hex_char(sum[3:0], cs == CS_LOWER));
			end
			CS_WRONG: begin
				sum ^= 8'($urandom_range(1, 255));
				put(CH_STAR);
				put(hex_char(sum[7:4], 0));
				put(hex_char(sum[3:0], 0));
			end
			CS_NOT_HEX: begin
				pick = $urandom_range(0, not_hex.len() - 1);
				put(CH_STAR);
				if ($urandom_range(0, 1)) begin
					put(not_hex[pick]);
					put(hex_char(sum[3:0], 0));
				end else begin
					put(hex_char(sum[7:4], 0));
					put(not_hex[pick]);
				end
			end
			default: begin
				// star with too few bytes behind it, or no star at all
				if ($urandom_range(0, 1)) begin
					put(CH_STAR);
					put(hex_char(sum[7:4], 0));
				end
			end
		endcase
		case (term)
			END_CRLF: begin
				put(CH_CR);
				put(CH_LF);
			end
			END_LF: put(CH_LF);
			END_CR: put(CH_CR);
			default: ;
		endcase
	endfunction

	function automatic void add_noise(int n);
		for (int i = 0; i < n; i++) tx_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void add_random_sentence();
		int         body_len;
		int         zero_at;
		int         r;
		logic [7:0] c;
		sum_style_t cs;
		line_end_t  term;
		begin_frame();
		case ($urandom_range(0, 11))
			0, 1: put_text("$GPRMC");
			2: put_text("$GNRMC");
			3, 4: put_text("$GPGGA");
			5: put_text("$GNGGA");
			6: put_text("$GPRMX");
			7: put_text("$GLGGA");
			8: put_text("$GP");
			9: put_text("$");
			10: put_text("$GNGG");
			default: begin
				put(CH_DOLLAR);
				for (int i = 0; i < 5; i++) put(8'($urandom_range(65, 90)));
			end
		endcase
		if (long_count < 3 && $urandom_range(0, 29) == 0) begin
			long_count++;
			body_len = $urandom_range(240, 300);
		end else begin
			body_len = $urandom_range(0, 24);
		end
		zero_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, body_len) : -1;
		for (int i = 0; i < body_len; i++) begin
			r = $urandom_range(0, 99);
			if (i == zero_at) c = CH_NUL;
			else if (r < 4) c = CH_STAR;
			else if (r < 8) c = 8'($urandom_range(128, 255));
			else begin
				c = 8'($urandom_range(32, 126));
				if (c == CH_DOLLAR || c == CH_STAR) c = 8'h2C;
			end
			put(c);
		end
		r = $urandom_range(0, 19);
		if (r < 12) cs = CS_UPPER;
		else if (r < 15) cs = CS_LOWER;
		else if (r < 17) cs = CS_WRONG;
		else if (r < 18) cs = CS_NOT_HEX;
		else cs = CS_NONE;
		r = $urandom_range(0, 19);
		if (r < 10) term = END_CRLF;
		else if (r < 12) term = END_LF;
		else if (r < 14) term = END_CR;
		else term = END_OPEN;
		finish_frame(cs, term);
	endfunction

	// stray bytes that only a dollar sign can close, star at index zero
	function automatic void add_headless();
		tx_bytes.push_back(CH_STAR);
		tx_bytes.push_back("0");
		tx_bytes.push_back("0");
		tx_bytes.push_back("a");
		tx_bytes.push_back("b");
		tx_bytes.push_back(CH_CR);
		tx_bytes.push_back("c");
		tx_bytes.push_back("d");
	endfunction

	task automatic push_byte(input logic [7:0] b);
		rx_byte <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.note_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_bytes();
		logic [7:0] b;
		while (tx_bytes.size() > 0) begin
			if (burst_left == 0) begin
				if (sender_gaps) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(negedge clk);
				end
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
			b = tx_bytes.pop_front();
			push_byte(b);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int phase;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed sentences, back to back
		tx_bytes.push_back(CH_LF);
		begin_frame();
		put_text("$GPRMC,123519,A");
		finish_frame(CS_UPPER, END_CRLF);
		begin_frame();
		put_text("$GNGGA,1,2");
		finish_frame(CS_LOWER, END_LF);
		begin_frame();
		put_text("$GNRMC,x");
		finish_frame(CS_UPPER, END_CR);
		begin_frame();
		put_text("$GPGGA,9");
		finish_frame(CS_WRONG, END_CRLF);
		begin_frame();
		put_text("$GPZDA,7");
		finish_frame(CS_NOT_HEX, END_CRLF);
		begin_frame();
		put_text("$GPR");
		finish_frame(CS_NONE, END_CRLF);
		add_headless();
		begin_frame();
		put_text("$GPGGA,1");
		put(CH_NUL);
		put_text("xy");
		finish_frame(CS_UPPER, END_CRLF);
		begin_frame();
		put_text("$GPRMC");
		put(8'hFF);
		put(8'h80);
		finish_frame(CS_UPPER, END_OPEN);
		tx_bytes.push_back(CH_DOLLAR);
		tx_bytes.push_back(CH_LF);
		send_bytes();
		drain();

		phase = 0;
		while (bytes_sent < 1700) begin
			sender_gaps = phase[0];
			stall_style = (phase / 2) % 4;
			while (tx_bytes.size() < 280) begin
				if ($urandom_range(0, 5) == 0) add_noise($urandom_range(1, 8));
				if ($urandom_range(0, 24) == 0) add_headless();
				add_random_sentence();
			end
			// long result-side hold while bytes keep coming
			if (phase % 5 == 2) begin
				sender_gaps = 0;
				hold_requests++;
			end
			send_bytes();
			drain();
			phase++;
		end

		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
